### src/sbtd_pkg.sv
// Shared constants, types and arithmetic helpers for the spectral bin transient detector.
package sbtd_pkg;

	localparam int NUM_BINS_DEF = 256;

	// Register indexes on the configuration port.
	localparam logic REG_DIFFICULTY  = 1'b0;
	localparam logic REG_ALWAYS_BINS = 1'b1;

	localparam logic [3:0] DIFFICULTY_RST  = 4'd1;
	localparam logic [8:0] ALWAYS_BINS_RST = 9'd20;

	// 0.15 in Q0.16, rounding half and 2.3 in Q2.16.
	localparam logic signed [31:0] BLEND_W   = 32'sd9830;
	localparam logic signed [31:0] BLEND_RND = 32'sd32768;
	localparam logic [17:0]        K_THRESH  = 18'd150733;

	typedef struct packed {
		logic        en;
		logic [7:0]  bin;
		logic [15:0] data;
	} wr_req_t;

	// Exponential average with weights 0.85 (old) and 0.15 (new), rounded.
	// The old weight is written as 1 - 0.15 so that one constant product remains.
	function automatic logic [15:0] blend(input logic [15:0] old_v, input logic [15:0] new_v);
		logic signed [31:0] d;
		logic signed [31:0] s;
		d = signed'({16'b0, new_v}) - signed'({16'b0, old_v});
		s = d * BLEND_W + BLEND_RND;
		return old_v + s[31:16];
	endfunction

endpackage

### src/spectral_bin_transient_detector.sv
// Top level of the spectral bin transient detector: pipeline, configuration and output buffer.
//
//  Channel   Direction  Handshake             Contents
//  s_*       in         s_tvalid / s_tready   one bin: index, magnitude, frame volume
//  m_*       out        m_tvalid / m_tready   one result: triggered flag, index, magnitude
//  cfg_*     in         cfg_we                register index and write data
//
// One bin is taken per cycle while s_tready is high; its result passes through five
// pipeline stages and the output register. The per-bin read-modify-write of both
// averages closes in a single stage through forwarding, which sets that rate.
// After reset a clearing pass zeroes every entry of both stores with s_tready low.
// A two-entry output buffer takes results while m_tready is low; s_tready falls at the
// edge at which the second entry fills, and the whole pipeline holds until that entry
// moves up into the output register.
module spectral_bin_transient_detector #(
	parameter int NUM_BINS = sbtd_pkg::NUM_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // bin_index[7:0], magnitude[23:8], frame_volume[39:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // triggered[0], out_bin_index[8:1], out_magnitude[24:9]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_wdata
);

	logic [3:0] difficulty_q;
	logic [8:0] always_bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			difficulty_q  <= sbtd_pkg::DIFFICULTY_RST;
			always_bins_q <= sbtd_pkg::ALWAYS_BINS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbtd_pkg::REG_DIFFICULTY:  difficulty_q  <= cfg_wdata[3:0];
				sbtd_pkg::REG_ALWAYS_BINS: always_bins_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic adv, accept, clearing;
	logic skd_vld_q;

	logic [7:0]  in_bin;
	logic [15:0] in_mag, in_vol;
	logic        in_alw, in_upd;

	assign in_bin = s_tdata[7:0];
	assign in_mag = s_tdata[23:8];
	assign in_vol = s_tdata[39:24];
	assign in_alw = {1'b0, in_bin} < always_bins_q;
	assign in_upd = !in_alw && (32'(in_bin) < NUM_BINS);

	assign adv      = !skd_vld_q;
	assign s_tready = adv && !clearing;
	assign accept   = s_tvalid && s_tready;

	// Stage registers.
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [7:0]  bin_s1, bin_s2, bin_s3, bin_s4, bin_s5;
	logic [15:0] mag_s1, mag_s2, mag_s3, mag_s4, mag_s5;
	logic        alw_s1, alw_s2, alw_s3, alw_s4, alw_s5;
	logic        upd_s1, upd_s2, upd_s3, upd_s4, upd_s5;
	logic [15:0] vol_s1;
	logic [15:0] avg_s2, delta_s2, p2_s2, dev_s2;
	logic [15:0] dev_s3, devold_s3, delta_s3, p2_s3, p4_s3;
	logic [15:0] delta_s4, p6_s4;
	logic [33:0] rhs_s4, rhs_s5;
	logic [31:0] prod_s5;

	sbtd_pkg::wr_req_t avg_wr, dev_wr;
	logic [15:0] rd_avg, rd_dev;

	sbtd_store #(
		.NUM_BINS (NUM_BINS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (adv),
		.rd_bin (in_bin),
		.avg_wr (avg_wr),
		.dev_wr (dev_wr),
		.rd_avg (rd_avg),
		.rd_dev (rd_dev),
		.busy   (clearing)
	);

	// Stage 1: the average of the same bin one item ahead has not reached the memory
	// read in time, so it is taken from stage 2. The deviation written by the item in
	// stage 3 landed in the same edge as this read and is forwarded likewise.
	logic        fwd_avg_s1, fwd_dev_s1, fwd_dev_s2;
	logic [15:0] avg_cur, dev_c1, dev_cur, delta_c, avg_new, dev_new;
	logic [31:0] p2_full, p4_full, p6_full;
	logic [16:0] diff_c;

	assign fwd_avg_s1 = vld_s2 && upd_s2 && (bin_s2 == bin_s1);
	assign fwd_dev_s1 = vld_s3 && upd_s3 && (bin_s3 == bin_s1);
	assign fwd_dev_s2 = vld_s3 && upd_s3 && (bin_s3 == bin_s2);

	always_comb begin
		avg_cur = fwd_avg_s1 ? avg_s2 : rd_avg;
		dev_c1  = fwd_dev_s1 ? dev_s3 : rd_dev;
		diff_c  = {1'b0, mag_s1} - {1'b0, avg_cur};
		delta_c = diff_c[16] ? 16'(-diff_c) : diff_c[15:0];
		avg_new = sbtd_pkg::blend(avg_cur, mag_s1);
		p2_full = 32'(vol_s1) * 32'(vol_s1);
	end

	// Stage 2: deviation update closes its own loop against stage 3.
	always_comb begin
		dev_cur = fwd_dev_s2 ? dev_s3 : dev_s2;
		dev_new = sbtd_pkg::blend(dev_cur, delta_s2);
		p4_full = 32'(p2_s2) * 32'(p2_s2);
	end

	// Stage 3 and 4 products.
	logic [33:0] rhs_c;
	logic [31:0] prod_c;
	assign p6_full = 32'(p4_s3) * 32'(p2_s3);
	assign rhs_c   = 34'(devold_s3) * 34'(sbtd_pkg::K_THRESH);
	assign prod_c  = 32'(delta_s4) * 32'(p6_s4);

	// Stage 5: difficulty scaling and the threshold compare.
	logic [35:0] lhs_c;
	logic        trig_c;
	assign lhs_c  = 36'(prod_s5) * 36'(difficulty_q);
	assign trig_c = alw_s5 || (upd_s5 && (lhs_c > 36'(rhs_s5)));

	always_comb begin
		avg_wr.en   = adv && vld_s1 && upd_s1;
		avg_wr.bin  = bin_s1;
		avg_wr.data = avg_new;
		dev_wr.en   = adv && vld_s2 && upd_s2;
		dev_wr.bin  = bin_s2;
		dev_wr.data = dev_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bin_s1    <= in_bin;
			mag_s1    <= in_mag;
			vol_s1    <= in_vol;
			alw_s1    <= in_alw;
			upd_s1    <= in_upd;

			bin_s2    <= bin_s1;
			mag_s2    <= mag_s1;
			alw_s2    <= alw_s1;
			upd_s2    <= upd_s1;
			avg_s2    <= avg_new;
			delta_s2  <= delta_c;
			p2_s2     <= p2_full[31:16];
			dev_s2    <= dev_c1;

			bin_s3    <= bin_s2;
			mag_s3    <= mag_s2;
			alw_s3    <= alw_s2;
			upd_s3    <= upd_s2;
			dev_s3    <= dev_new;
			devold_s3 <= dev_cur;
			delta_s3  <= delta_s2;
			p2_s3     <= p2_s2;
			p4_s3     <= p4_full[31:16];

			bin_s4    <= bin_s3;
			mag_s4    <= mag_s3;
			alw_s4    <= alw_s3;
			upd_s4    <= upd_s3;
			delta_s4  <= delta_s3;
			p6_s4     <= p6_full[31:16];
			rhs_s4    <= rhs_c;

			bin_s5    <= bin_s4;
			mag_s5    <= mag_s4;
			alw_s5    <= alw_s4;
			upd_s5    <= upd_s4;
			prod_s5   <= prod_c;
			rhs_s5    <= rhs_s4;
		end
	end

	// Output register with one skid entry behind it.
	logic        out_vld_q;
	logic        out_trig_q, skd_trig_q;
	logic [7:0]  out_bin_q, skd_bin_q;
	logic [15:0] out_mag_q, skd_mag_q;
	logic        take, out_free;

	assign take     = out_vld_q && m_tready;
	assign out_free = !out_vld_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else if (adv) begin
			if (out_free) begin
				out_vld_q <= vld_s5;
			end else if (vld_s5) begin
				skd_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b1;
			skd_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (out_free) begin
				out_trig_q <= trig_c;
				out_bin_q  <= bin_s5;
				out_mag_q  <= mag_s5;
			end else begin
				skd_trig_q <= trig_c;
				skd_bin_q  <= bin_s5;
				skd_mag_q  <= mag_s5;
			end
		end else if (take) begin
			out_trig_q <= skd_trig_q;
			out_bin_q  <= skd_bin_q;
			out_mag_q  <= skd_mag_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_mag_q, out_bin_q, out_trig_q};

endmodule

### src/sbtd_store.sv
// Per-bin average and mean-deviation memories with the clearing pass after reset.
module sbtd_store #(
	parameter int NUM_BINS = sbtd_pkg::NUM_BINS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [7:0]       rd_bin,
	input  sbtd_pkg::wr_req_t avg_wr,
	input  sbtd_pkg::wr_req_t dev_wr,
	output logic [15:0]      rd_avg,
	output logic [15:0]      rd_dev,
	output logic             busy
);

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	logic [15:0] avg_mem [NUM_BINS];
	logic [15:0] dev_mem [NUM_BINS];

	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	logic [31:0]   rd_ext, avg_ext, dev_ext;
	logic [AW-1:0] rd_addr;
	logic          avg_we, dev_we;
	logic [AW-1:0] avg_wa, dev_wa;
	logic [15:0]   avg_wd, dev_wd;
	logic [15:0]   rd_avg_q, rd_dev_q;

	assign rd_ext  = 32'(rd_bin);
	assign avg_ext = 32'(avg_wr.bin);
	assign dev_ext = 32'(dev_wr.bin);
	assign rd_addr = rd_ext[AW-1:0];

	// The clearing pass owns both write ports until every entry holds zero.
	always_comb begin
		avg_we = clr_q | avg_wr.en;
		dev_we = clr_q | dev_wr.en;
		avg_wa = clr_q ? clr_cnt_q : avg_ext[AW-1:0];
		dev_wa = clr_q ? clr_cnt_q : dev_ext[AW-1:0];
		avg_wd = clr_q ? 16'd0 : avg_wr.data;
		dev_wd = clr_q ? 16'd0 : dev_wr.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == AW'(NUM_BINS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (avg_we) begin
			avg_mem[avg_wa] <= avg_wd;
		end
		if (dev_we) begin
			dev_mem[dev_wa] <= dev_wd;
		end
		if (rd_en) begin
			rd_avg_q <= avg_mem[rd_addr];
			rd_dev_q <= dev_mem[rd_addr];
		end
	end

	assign rd_avg = rd_avg_q;
	assign rd_dev = rd_dev_q;
	assign busy   = clr_q;

endmodule
